### rtl/swt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// swt_pkg
// Types and character codes shared by the shell word tokenizer modules.
// ----------------------------------------------------------------------------
package swt_pkg;

    typedef enum logic [2:0] {
        SCAN_GAP  = 3'd0,
        SCAN_WORD = 3'd1,
        SCAN_SQ   = 3'd2,
        SCAN_DQ   = 3'd3,
        SCAN_DQBS = 3'd4,
        SCAN_BS   = 3'd5,
        SCAN_DROP = 3'd6
    } scan_mode_t;

    typedef enum logic [1:0] {
        KIND_BYTE     = 2'd0,
        KIND_WORD_END = 2'd1,
        KIND_CMD_END  = 2'd2
    } item_kind_t;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0a;
    localparam logic [7:0] CH_CR     = 8'h0d;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_STAR   = 8'h2a;
    localparam logic [7:0] CH_QMARK  = 8'h3f;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_BTICK  = 8'h60;
    localparam logic [7:0] CH_QSTAR  = 8'h01;
    localparam logic [7:0] CH_QQMARK = 8'h02;

    localparam int MAX_RESULTS = 3;
    localparam int RES_DEPTH   = 8;
    localparam int RES_PTR_W   = 3;
    localparam int RES_CNT_W   = 4;

    typedef struct packed {
        item_kind_t  kind;
        logic [7:0]  data;
        logic [5:0]  word;
        logic        last;
    } result_t;

    typedef struct packed {
        logic [1:0]        count;
        result_t [2:0]     res;
    } result_group_t;

    function automatic logic is_space(input logic [7:0] b);
        return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_CR) || (b == CH_LF);
    endfunction

    function automatic logic [7:0] quoted(input logic [7:0] b);
        if (b == CH_STAR)
            return CH_QSTAR;
        else if (b == CH_QMARK)
            return CH_QQMARK;
        return b;
    endfunction

    function automatic logic dq_special(input logic [7:0] b);
        return (b == CH_DQUOTE) || (b == CH_DOLLAR) || (b == CH_BSLASH) ||
               (b == CH_BTICK) || (b == CH_LF);
    endfunction

endpackage
`default_nettype wire

### rtl/shell_word_tokenizer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// shell_word_tokenizer
// Splits a command text into shell words, one text byte per request.
//
// Input channel text_valid/text_ready carries text_byte; byte 0 ends the
// command. Output channel result_valid/result_ready carries item_kind,
// out_byte, word_number and last, one result item per request.
// A byte is held in an input register and scanned there; its results are
// written to an eight-entry result queue once the queue has room, and the
// output shows the head of that queue, so a result passes the input
// register and the queue before it appears.
// One byte is taken per cycle while the queue has room. The output side moves
// one result per cycle while the receiver is ready, so bytes causing two or
// three results (escapes in double quotes, command end) grow the queue, and
// the input is held while the queue holds more than five results.
// Reset empties the input register and the queue and returns the scanner to
// between words with no words counted. When the receiver stalls, results
// wait in the queue and the input keeps being taken until the queue holds
// more than five results.
// ----------------------------------------------------------------------------
module shell_word_tokenizer
    import swt_pkg::*;
#(
    parameter int MAX_TOKENS = 64
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       text_valid,
    output logic            text_ready,
    input  wire logic [7:0] text_byte,
    output logic            result_valid,
    input  wire logic       result_ready,
    output logic [1:0]      item_kind,
    output logic [7:0]      out_byte,
    output logic [5:0]      word_number,
    output logic            last
);

    localparam int CNT_W = $clog2(MAX_TOKENS);

    logic [7:0]       byte_reg;
    logic             full_reg;
    logic             full_next;
    scan_mode_t       mode_reg;
    scan_mode_t       mode_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    result_group_t    group;
    result_t          head;
    logic             space_ok;
    logic             fire;
    logic             take;

    assign fire       = full_reg && space_ok;
    assign text_ready = !full_reg || fire;
    assign take       = text_valid && text_ready;
    assign full_next  = take || (full_reg && !fire);

    swt_scan #(
        .MAX_TOKENS (MAX_TOKENS),
        .CNT_W      (CNT_W)
    ) u_scan (
        .text_byte  (byte_reg),
        .mode       (mode_reg),
        .count      (count_reg),
        .mode_next  (mode_next),
        .count_next (count_next),
        .group      (group)
    );

    swt_result_fifo u_fifo (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (fire),
        .group        (group),
        .space_ok     (space_ok),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .head         (head)
    );

    always_ff @(posedge clk)
    begin
        if (take)
            byte_reg <= text_byte;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg  <= 1'b0;
            mode_reg  <= SCAN_GAP;
            count_reg <= '0;
        end
        else
        begin
            full_reg <= full_next;
            if (fire)
            begin
                mode_reg  <= mode_next;
                count_reg <= count_next;
            end
        end
    end

    assign item_kind   = head.kind;
    assign out_byte    = head.data;
    assign word_number = head.word;
    assign last        = head.last;

endmodule
`default_nettype wire

### rtl/swt_scan.sv
`default_nettype none
// ----------------------------------------------------------------------------
// swt_scan
// Per-byte scanner: from one text byte and the current scan state, works out
// the next state and the up to three result items the byte causes.
// ----------------------------------------------------------------------------
module swt_scan
    import swt_pkg::*;
#(
    parameter int MAX_TOKENS = 64,
    parameter int CNT_W      = 6
)
(
    input  wire logic [7:0]       text_byte,
    input  wire scan_mode_t       mode,
    input  wire logic [CNT_W-1:0] count,
    output scan_mode_t            mode_next,
    output logic [CNT_W-1:0]      count_next,
    output result_group_t         group
);

    localparam logic [CNT_W-1:0] LIMIT = CNT_W'(MAX_TOKENS - 1);

    logic [6:0] count7;
    logic [5:0] word_cur;
    logic [5:0] word_prev;
    logic       at_limit;

    assign count7    = 7'(count);
    assign word_cur  = count7[5:0];
    assign word_prev = 6'(count7 - 7'd1);
    assign at_limit  = (count >= LIMIT);

    // next state
    always_comb
    begin
        scan_mode_t cur;
        logic       go;
        cur        = mode;
        go         = 1'b1;
        mode_next  = mode;
        count_next = count;
        if (text_byte == CH_NUL)
        begin
            mode_next  = SCAN_GAP;
            count_next = '0;
        end
        else if (mode == SCAN_DROP)
        begin
            mode_next = SCAN_DROP;
        end
        else
        begin
            if (cur != SCAN_WORD && cur != SCAN_SQ && cur != SCAN_DQ &&
                cur != SCAN_DQBS && cur != SCAN_BS)
            begin
                if (is_space(text_byte))
                begin
                    go        = 1'b0;
                    mode_next = SCAN_GAP;
                end
                else if (at_limit)
                begin
                    go        = 1'b0;
                    mode_next = SCAN_DROP;
                end
                else
                begin
                    count_next = count + CNT_W'(1);
                    cur        = SCAN_WORD;
                end
            end
            if (go && cur == SCAN_DQBS)
            begin
                if (dq_special(text_byte))
                begin
                    go        = 1'b0;
                    mode_next = SCAN_DQ;
                end
                else
                begin
                    cur = SCAN_DQ;
                end
            end
            if (go)
            begin
                unique case (cur)
                    SCAN_SQ:
                    begin
                        mode_next = (text_byte == CH_SQUOTE) ? SCAN_WORD : SCAN_SQ;
                    end
                    SCAN_DQ:
                    begin
                        if (text_byte == CH_DQUOTE)
                            mode_next = SCAN_WORD;
                        else if (text_byte == CH_BSLASH)
                            mode_next = SCAN_DQBS;
                        else
                            mode_next = SCAN_DQ;
                    end
                    SCAN_BS:
                    begin
                        mode_next = SCAN_WORD;
                    end
                    default:
                    begin
                        if (text_byte == CH_BSLASH)
                            mode_next = SCAN_BS;
                        else if (text_byte == CH_SQUOTE)
                            mode_next = SCAN_SQ;
                        else if (text_byte == CH_DQUOTE)
                            mode_next = SCAN_DQ;
                        else if (is_space(text_byte))
                            mode_next = SCAN_GAP;
                        else
                            mode_next = SCAN_WORD;
                    end
                endcase
            end
        end
    end

    // result items
    always_comb
    begin
        scan_mode_t    cur;
        logic          go;
        logic [1:0]    n;
        logic [5:0]    w;
        result_t [2:0] res;
        cur = mode;
        go  = 1'b1;
        n   = 2'd0;
        w   = word_prev;
        res = '0;
        if (text_byte == CH_NUL)
        begin
            if (mode == SCAN_DQBS)
            begin
                res[n] = '{kind: KIND_BYTE, data: CH_BSLASH, word: w, last: 1'b0};
                n      = n + 2'd1;
            end
            if (mode == SCAN_WORD || mode == SCAN_SQ || mode == SCAN_DQ ||
                mode == SCAN_DQBS || mode == SCAN_BS)
            begin
                res[n] = '{kind: KIND_WORD_END, data: 8'h00, word: w, last: 1'b0};
                n      = n + 2'd1;
            end
            res[n] = '{kind: KIND_CMD_END, data: 8'h00, word: word_cur, last: 1'b0};
            n      = n + 2'd1;
        end
        else if (mode != SCAN_DROP)
        begin
            if (cur != SCAN_WORD && cur != SCAN_SQ && cur != SCAN_DQ &&
                cur != SCAN_DQBS && cur != SCAN_BS)
            begin
                if (is_space(text_byte) || at_limit)
                begin
                    go = 1'b0;
                end
                else
                begin
                    w   = word_cur;
                    cur = SCAN_WORD;
                end
            end
            if (go && cur == SCAN_DQBS)
            begin
                if (dq_special(text_byte))
                begin
                    res[n] = '{kind: KIND_BYTE, data: text_byte, word: w, last: 1'b0};
                    n      = n + 2'd1;
                    go     = 1'b0;
                end
                else
                begin
                    res[n] = '{kind: KIND_BYTE, data: CH_BSLASH, word: w, last: 1'b0};
                    n      = n + 2'd1;
                    cur    = SCAN_DQ;
                end
            end
            if (go)
            begin
                unique case (cur)
                    SCAN_SQ:
                    begin
                        if (text_byte != CH_SQUOTE)
                        begin
                            res[n] = '{kind: KIND_BYTE, data: quoted(text_byte),
                                       word: w, last: 1'b0};
                            n      = n + 2'd1;
                        end
                    end
                    SCAN_DQ:
                    begin
                        if (text_byte != CH_DQUOTE && text_byte != CH_BSLASH)
                        begin
                            res[n] = '{kind: KIND_BYTE, data: quoted(text_byte),
                                       word: w, last: 1'b0};
                            n      = n + 2'd1;
                        end
                    end
                    SCAN_BS:
                    begin
                        res[n] = '{kind: KIND_BYTE, data: quoted(text_byte),
                                   word: w, last: 1'b0};
                        n      = n + 2'd1;
                    end
                    default:
                    begin
                        if (is_space(text_byte))
                        begin
                            res[n] = '{kind: KIND_WORD_END, data: 8'h00, word: w,
                                       last: 1'b0};
                            n      = n + 2'd1;
                        end
                        else if (text_byte != CH_BSLASH && text_byte != CH_SQUOTE &&
                                 text_byte != CH_DQUOTE)
                        begin
                            res[n] = '{kind: KIND_BYTE, data: text_byte, word: w,
                                       last: 1'b0};
                            n      = n + 2'd1;
                        end
                    end
                endcase
            end
        end
        for (int i = 0; i < MAX_RESULTS; i++)
        begin
            res[i].last = (n != 2'd0) && (2'(i) == n - 2'd1);
        end
        group.count = n;
        group.res   = res;
    end

endmodule
`default_nettype wire

### rtl/swt_result_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// swt_result_fifo
// Result queue: takes a group of up to three result items in one cycle and
// hands them out one per request on the output channel.
// ----------------------------------------------------------------------------
module swt_result_fifo
    import swt_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire result_group_t group,
    output logic               space_ok,
    output logic               result_valid,
    input  wire logic          result_ready,
    output result_t            head
);

    result_t              mem [RES_DEPTH];
    logic [RES_PTR_W-1:0] wr_ptr_reg;
    logic [RES_PTR_W-1:0] wr_ptr_next;
    logic [RES_PTR_W-1:0] rd_ptr_reg;
    logic [RES_PTR_W-1:0] rd_ptr_next;
    logic [RES_CNT_W-1:0] count_reg;
    logic [RES_CNT_W-1:0] count_next;
    logic [1:0]           push_n;
    logic                 pop;

    assign push_n       = push ? group.count : 2'd0;
    assign pop          = result_valid && result_ready;
    assign result_valid = (count_reg != '0);
    assign space_ok     = (count_reg <= RES_CNT_W'(RES_DEPTH - MAX_RESULTS));
    assign head         = mem[rd_ptr_reg];

    assign wr_ptr_next = wr_ptr_reg + RES_PTR_W'(push_n);
    assign rd_ptr_next = rd_ptr_reg + RES_PTR_W'(pop);
    assign count_next  = count_reg + RES_CNT_W'(push_n) - RES_CNT_W'(pop);

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_RESULTS; i++)
        begin
            if (2'(i) < push_n)
                mem[wr_ptr_reg + RES_PTR_W'(i)] <= group.res[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule
`default_nettype wire

### dv/shell_word_tokenizer_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shell_word_tokenizer_test
// Self-checking testbench for the shell word tokenizer.
//
// Sends command text one byte per request. A short table of directed bytes
// comes first, covering quotes, escapes, empty words and commands that end
// inside quotes or after a backslash. Random commands follow. Most are built
// from plain, quoted and escaped pieces. Some end in a broken way, some are
// noise, and one runs past the word limit. A scanner model in the bench
// predicts all results but those fixed in the first rows. All are checked
// in order, field by field. Channels idle at random except in one stretch.
// ----------------------------------------------------------------------------
module shell_word_tokenizer_test;
    import swt_pkg::*;

    localparam int TOKEN_LIMIT    = 64;
    localparam int TEXT_ITEMS     = 260;
    localparam int LIMIT_AFTER    = 90;
    localparam int IDLE_PERCENT   = 14;
    localparam int STEADY_FIRST   = 60;
    localparam int STEADY_LAST    = 140;
    localparam int DRAIN_CYCLES   = 20;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DIRECTED_ROWS  = 24;

    typedef struct packed {
        logic [7:0] text;
        logic       fixed;
        logic       has_result;
        result_t    fixed_res;
    } text_req_t;

    localparam result_t NO_RESULT = '{KIND_BYTE, 8'h00, 6'd0, 1'b0};

    localparam logic [7:0] MARKS [11] = '{
        CH_STAR, CH_QMARK, CH_DOLLAR, CH_BTICK, CH_DQUOTE, CH_SQUOTE, CH_BSLASH,
        CH_SPACE, CH_TAB, CH_CR, CH_LF
    };

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       text_valid = 1'b0;
    logic       text_ready;
    logic [7:0] text_byte = 8'h00;
    logic       result_valid;
    logic       result_ready = 1'b0;
    logic [1:0] item_kind;
    logic [7:0] out_byte;
    logic [5:0] word_number;
    logic       last;

    text_req_t  text_q [$];
    result_t    expected_q [$];
    text_req_t  directed [DIRECTED_ROWS];
    scan_mode_t tok_mode = SCAN_GAP;
    logic [6:0] tok_words = 7'd0;
    int         errors = 0;
    int         text_taken = 0;
    int         quiet = 0;
    logic       steady;

    assign steady = (text_taken >= STEADY_FIRST) && (text_taken < STEADY_LAST);

    shell_word_tokenizer #(
        .MAX_TOKENS(TOKEN_LIMIT)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .text_valid(text_valid),
        .text_ready(text_ready),
        .text_byte(text_byte),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .item_kind(item_kind),
        .out_byte(out_byte),
        .word_number(word_number),
        .last(last)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        errors++;
    endtask

    function automatic logic is_blank(input logic [7:0] b);
        return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_CR) || (b == CH_LF);
    endfunction

    function automatic logic [7:0] literal_of(input logic [7:0] b);
        return (b == CH_STAR) ? CH_QSTAR : ((b == CH_QMARK) ? CH_QQMARK : b);
    endfunction

    // scanner model: advances its state on one byte, queues the results when keep is set
    function automatic void scan_text(input logic [7:0] b, input logic keep);
        scan_mode_t m;
        logic [6:0] w;
        result_t    got [$];
        m = tok_mode;
        w = tok_words - 7'd1;
        if (b == CH_NUL)
        begin
            if (m == SCAN_DQBS)
                got.push_back(result_t'{KIND_BYTE, CH_BSLASH, w[5:0], 1'b0});
            if ((m != SCAN_GAP) && (m != SCAN_DROP))
                got.push_back(result_t'{KIND_WORD_END, 8'h00, w[5:0], 1'b0});
            got.push_back(result_t'{KIND_CMD_END, 8'h00, tok_words[5:0], 1'b0});
            m = SCAN_GAP;
            tok_words = 7'd0;
        end
        else if ((m == SCAN_GAP) && !is_blank(b) && (tok_words >= 7'(TOKEN_LIMIT - 1)))
        begin
            m = SCAN_DROP;
        end
        else if ((m != SCAN_DROP) && !((m == SCAN_GAP) && is_blank(b)))
        begin
            if (m == SCAN_GAP)
            begin
                w = tok_words;
                tok_words = tok_words + 7'd1;
                m = SCAN_WORD;
            end
            if ((m == SCAN_DQBS) && ((b == CH_DQUOTE) || (b == CH_DOLLAR) ||
                (b == CH_BSLASH) || (b == CH_BTICK) || (b == CH_LF)))
            begin
                got.push_back(result_t'{KIND_BYTE, b, w[5:0], 1'b0});
                m = SCAN_DQ;
            end
            else
            begin
                // backslash before an ordinary byte in double quotes is kept
                if (m == SCAN_DQBS)
                begin
                    got.push_back(result_t'{KIND_BYTE, CH_BSLASH, w[5:0], 1'b0});
                    m = SCAN_DQ;
                end
                case (m)
                    SCAN_SQ:
                    begin
                        if (b == CH_SQUOTE)
                            m = SCAN_WORD;
                        else
                            got.push_back(result_t'{KIND_BYTE, literal_of(b), w[5:0], 1'b0});
                    end
                    SCAN_DQ:
                    begin
                        if (b == CH_DQUOTE)
                            m = SCAN_WORD;
                        else if (b == CH_BSLASH)
                            m = SCAN_DQBS;
                        else
                            got.push_back(result_t'{KIND_BYTE, literal_of(b), w[5:0], 1'b0});
                    end
                    SCAN_BS:
                    begin
                        got.push_back(result_t'{KIND_BYTE, literal_of(b), w[5:0], 1'b0});
                        m = SCAN_WORD;
                    end
                    default:
                    begin
                        if (b == CH_BSLASH)
                            m = SCAN_BS;
                        else if (b == CH_SQUOTE)
                            m = SCAN_SQ;
                        else if (b == CH_DQUOTE)
                            m = SCAN_DQ;
                        else if (is_blank(b))
                        begin
                            got.push_back(result_t'{KIND_WORD_END, 8'h00, w[5:0], 1'b0});
                            m = SCAN_GAP;
                        end
                        else
                            got.push_back(result_t'{KIND_BYTE, b, w[5:0], 1'b0});
                    end
                endcase
            end
        end
        tok_mode = m;
        if (got.size() > 0)
            got[got.size() - 1].last = 1'b1;
        if (keep)
            foreach (got[i])
                expected_q.push_back(got[i]);
    endfunction

    function automatic logic [7:0] pick_byte();
        logic [7:0] v;
        case ($urandom_range(0, 3))
            0, 1:
            begin
                v = 8'($urandom_range(0, 25));
                v = v + 8'h61;
            end
            2:
                v = MARKS[4'($urandom_range(0, 10))];
            default:
                v = 8'($urandom_range(1, 255));
        endcase
        return v;
    endfunction

    function automatic void add_text(input logic [7:0] b);
        text_q.push_back(text_req_t'{b, 1'b0, 1'b0, NO_RESULT});
    endfunction

    // request side
    always @(posedge clk)
    begin
        text_req_t head;
        if (rst_n)
        begin
            if (text_valid && text_ready)
            begin
                head = text_q.pop_front();
                scan_text(head.text, !head.fixed);
                if (head.fixed && head.has_result)
                    expected_q.push_back(head.fixed_res);
                text_taken <= text_taken + 1;
            end
            if (!text_valid || text_ready)
            begin
                if ((text_q.size() > 0) && (steady || ($urandom_range(0, 99) >= IDLE_PERCENT)))
                begin
                    text_valid <= 1'b1;
                    text_byte  <= text_q[0].text;
                end
                else
                    text_valid <= 1'b0;
            end
        end
    end

    // result side
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n)
        begin
            if (result_valid && result_ready)
            begin
                if (expected_q.size() == 0)
                    report_mismatch($sformatf("unexpected kind %0d byte %02h word %0d last %0b",
                        item_kind, out_byte, word_number, last));
                else
                begin
                    want = expected_q.pop_front();
                    if ((item_kind !== want.kind) || (out_byte !== want.data) ||
                        (word_number !== want.word) || (last !== want.last))
                        report_mismatch($sformatf(
                            "got kind %0d byte %02h word %0d last %0b, want %0d %02h %0d %0b",
                            item_kind, out_byte, word_number, last,
                            want.kind, want.data, want.word, want.last));
                end
            end
            result_ready <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (text_valid && text_ready) || (result_valid && result_ready))
            quiet <= 0;
        else if (quiet >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no request moved for %0d cycles", quiet);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        else
            quiet <= quiet + 1;
    end

    initial
    begin
        logic [7:0] b;
        int         words;
        logic       limit_done;
        limit_done = 1'b0;
        directed = '{
            '{CH_NUL,    1'b1, 1'b1, '{KIND_CMD_END,  8'h00, 6'd0, 1'b1}},
            '{8'hff,     1'b1, 1'b1, '{KIND_BYTE,     8'hff, 6'd0, 1'b1}},
            '{CH_SPACE,  1'b1, 1'b1, '{KIND_WORD_END, 8'h00, 6'd0, 1'b1}},
            '{CH_SQUOTE, 1'b1, 1'b0, NO_RESULT},
            '{CH_QMARK,  1'b0, 1'b0, NO_RESULT},
            '{CH_SQUOTE, 1'b0, 1'b0, NO_RESULT},
            '{CH_DQUOTE, 1'b0, 1'b0, NO_RESULT},
            '{CH_STAR,   1'b0, 1'b0, NO_RESULT},
            '{CH_BSLASH, 1'b0, 1'b0, NO_RESULT},
            '{8'h61,     1'b0, 1'b0, NO_RESULT},
            '{CH_BSLASH, 1'b0, 1'b0, NO_RESULT},
            '{CH_LF,     1'b0, 1'b0, NO_RESULT},
            '{CH_DQUOTE, 1'b0, 1'b0, NO_RESULT},
            '{CH_TAB,    1'b0, 1'b0, NO_RESULT},
            '{CH_BSLASH, 1'b0, 1'b0, NO_RESULT},
            '{CH_CR,     1'b0, 1'b0, NO_RESULT},
            '{CH_BSLASH, 1'b0, 1'b0, NO_RESULT},
            '{CH_NUL,    1'b0, 1'b0, NO_RESULT},
            '{CH_SQUOTE, 1'b0, 1'b0, NO_RESULT},
            '{CH_SQUOTE, 1'b0, 1'b0, NO_RESULT},
            '{CH_CR,     1'b0, 1'b0, NO_RESULT},
            '{CH_DQUOTE, 1'b0, 1'b0, NO_RESULT},
            '{CH_BSLASH, 1'b0, 1'b0, NO_RESULT},
            '{CH_NUL,    1'b0, 1'b0, NO_RESULT}
        };
        foreach (directed[i])
            text_q.push_back(directed[i]);

        while (text_q.size() < TEXT_ITEMS)
        begin
            if (!limit_done && (text_q.size() >= LIMIT_AFTER))
            begin
                // more words than the limit, mixing empty quoted words
                for (int k = 0; k < TOKEN_LIMIT + 2; k++)
                begin
                    if (k % 4 == 0)
                    begin
                        add_text(CH_SQUOTE);
                        add_text(CH_SQUOTE);
                    end
                    else
                    begin
                        b = 8'(k % 26);
                        add_text(b + 8'h61);
                    end
                    add_text(CH_SPACE);
                end
                add_text(CH_DQUOTE);
                add_text(8'h7a);
                add_text(CH_NUL);
                limit_done = 1'b1;
            end
            else if ($urandom_range(0, 9) == 0)
            begin
                // noise
                repeat ($urandom_range(1, 8))
                    add_text(8'($urandom_range(0, 255)));
                add_text(CH_NUL);
            end
            else
            begin
                words = $urandom_range(0, 5);
                if ($urandom_range(0, 3) == 0)
                    add_text(MARKS[4'($urandom_range(7, 10))]);
                for (int k = 0; k < words; k++)
                begin
                    repeat ($urandom_range(1, 3))
                    begin
                        case ($urandom_range(0, 3))
                            0:
                            begin
                                repeat ($urandom_range(1, 3))
                                begin
                                    b = pick_byte();
                                    if (is_blank(b) || (b == CH_SQUOTE) || (b == CH_DQUOTE) ||
                                        (b == CH_BSLASH))
                                        b = 8'h5f;
                                    add_text(b);
                                end
                            end
                            1:
                            begin
                                add_text(CH_SQUOTE);
                                repeat ($urandom_range(0, 3))
                                begin
                                    b = pick_byte();
                                    add_text((b == CH_SQUOTE) ? 8'h2d : b);
                                end
                                add_text(CH_SQUOTE);
                            end
                            2:
                            begin
                                add_text(CH_DQUOTE);
                                repeat ($urandom_range(0, 3))
                                begin
                                    b = pick_byte();
                                    if ((b == CH_DQUOTE) || (b == CH_BSLASH) ||
                                        ($urandom_range(0, 4) == 0))
                                        add_text(CH_BSLASH);
                                    add_text(b);
                                end
                                add_text(CH_DQUOTE);
                            end
                            default:
                            begin
                                add_text(CH_BSLASH);
                                add_text(pick_byte());
                            end
                        endcase
                    end
                    if ((k < words - 1) || ($urandom_range(0, 1) == 1))
                        repeat ($urandom_range(1, 2))
                            add_text(MARKS[4'($urandom_range(7, 10))]);
                end
                // broken endings: open quote or pending backslash
                case ($urandom_range(0, 7))
                    0: add_text(CH_SQUOTE);
                    1: add_text(CH_DQUOTE);
                    2: add_text(CH_BSLASH);
                    3:
                    begin
                        add_text(CH_DQUOTE);
                        add_text(CH_BSLASH);
                    end
                    default: ;
                endcase
                add_text(CH_NUL);
            end
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        while ((text_q.size() > 0) || text_valid || (expected_q.size() > 0))
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

### files.f
rtl/swt_pkg.sv
rtl/swt_scan.sv
rtl/swt_result_fifo.sv
rtl/shell_word_tokenizer.sv
dv/shell_word_tokenizer_test.sv
